/* src/hsv_pkg.sv */
package hsv_pkg;

  localparam int CW = 16;
  localparam int DW = CW + 3;
  localparam int NST = CW + 1;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;
  localparam logic [CW-1:0] CMAX = '1;

  localparam logic [1:0] K_NORM  = 2'd0;
  localparam logic [1:0] K_BLACK = 2'd1;
  localparam logic [1:0] K_GREY  = 2'd2;
  localparam logic [1:0] K_FLAT  = 2'd3;

  localparam logic DIR_HSB2RGB = 1'b0;

  typedef struct packed {
    logic [CW-1:0] in_first;
    logic [CW-1:0] in_second;
    logic [CW-1:0] in_third;
  } hsv_in_t;

  typedef struct packed {
    logic [CW-1:0] out_first;
    logic [CW-1:0] out_second;
    logic [CW-1:0] out_third;
  } hsv_out_t;

  typedef struct packed {
    logic          dir;
    logic [1:0]    kind;
    logic [2:0]    sector;
    logic [CW-1:0] v;
    logic [CW-1:0] s;
    logic [CW-1:0] q;
    logic [CW-1:0] delta;
    logic [DW-1:0] n;
    logic [DW-1:0] d6;
  } hsv_item_t;

  typedef struct packed {
    logic            dir;
    logic [1:0]      kind;
    logic [2:0]      sector;
    logic [CW-1:0]   v;
    logic [2*CW-1:0] p0;
    logic [2*CW-1:0] p1;
    logic [2*CW-1:0] p2;
    logic [CW-1:0]   f1;
    logic [CW-1:0]   f2;
    logic [CW-1:0]   f3;
    logic [DW-1:0]   rs;
    logic [DW-1:0]   ds;
    logic [CW-1:0]   ls;
    logic [CW-1:0]   qs;
    logic [DW-1:0]   rh;
    logic [DW-1:0]   dh;
    logic [CW-1:0]   qh;
  } hsv_work_t;

  // product divided by the full-scale value
  function automatic logic [CW-1:0] cdiv(input logic [2*CW-1:0] p);
    logic [CW-1:0] hi;
    logic [CW:0]   r;
    hi = p[2*CW-1:CW];
    r = {1'b0, p[CW-1:0]} + {1'b0, hi};
    cdiv = hi + CW'(r >= {1'b0, CMAX});
  endfunction

  // one restoring division step: {remainder, quotient bit}
  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic bin,
                                           input logic [DW-1:0] d);
    logic [DW:0] r2;
    logic [DW:0] dif;
    r2 = {rem, bin};
    dif = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      div_step = {dif[DW-1:0], 1'b1};
    end else begin
      div_step = {r2[DW-1:0], 1'b0};
    end
  endfunction

endpackage

/* src/hsv_front.sv */
module hsv_front (
  input  logic              dir,
  input  hsv_pkg::hsv_in_t  data,
  output hsv_pkg::hsv_item_t item
);

  logic [hsv_pkg::CW-1:0] r, g, b, mx, mn, dl;
  logic [hsv_pkg::DW-1:0] h6;
  logic signed [hsv_pkg::DW+1:0] n0, n1;

  always_comb begin
    r = data.in_first;
    g = data.in_second;
    b = data.in_third;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    h6 = hsv_pkg::DW'(r) * hsv_pkg::DW'(6);
    if (r == mx) begin
      n0 = $signed({4'b0, g}) - $signed({4'b0, b});
    end else if (g == mx) begin
      n0 = $signed({3'b0, dl, 1'b0}) + $signed({4'b0, b}) - $signed({4'b0, r});
    end else begin
      n0 = $signed({2'b0, dl, 2'b0}) + $signed({4'b0, r}) - $signed({4'b0, g});
    end
    n1 = n0 + $signed({2'b0, dl, 2'b0}) + $signed({3'b0, dl, 1'b0});
    item.dir = dir;
    item.delta = dl;
    item.d6 = {1'b0, dl, 2'b0} + {2'b0, dl, 1'b0};
    item.n = (n0 < 0) ? n1[hsv_pkg::DW-1:0] : n0[hsv_pkg::DW-1:0];
    if (dir == hsv_pkg::DIR_HSB2RGB) begin
      item.v = b;
      item.s = g;
      item.q = h6[hsv_pkg::CW-1:0];
      item.sector = h6[hsv_pkg::DW-1:hsv_pkg::CW];
      if (b == '0) item.kind = hsv_pkg::K_BLACK;
      else if (g == '0) item.kind = hsv_pkg::K_GREY;
      else item.kind = hsv_pkg::K_NORM;
    end else begin
      item.v = mx;
      item.s = '0;
      item.q = '0;
      item.sector = '0;
      item.kind = (dl == '0) ? hsv_pkg::K_FLAT : hsv_pkg::K_NORM;
    end
  end

endmodule

/* src/hsv_queue.sv */
module hsv_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  hsv_pkg::hsv_item_t wdata,
  output logic               full,
  input  logic               rd,
  output hsv_pkg::hsv_item_t rdata,
  output logic               nonempty
);

  hsv_pkg::hsv_item_t mem [hsv_pkg::QDEPTH];
  logic [hsv_pkg::QAW-1:0] wp, rp;
  logic [hsv_pkg::QAW:0] count;

  assign full = (count == (hsv_pkg::QAW+1)'(hsv_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (hsv_pkg::QAW+1)'(wr) - (hsv_pkg::QAW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (hsv_pkg::QAW+1)'(hsv_pkg::QDEPTH))
    else $error("queue count overflow");
  a_rd_nonempty: assert property (@(posedge clk) disable iff (rst) rd |-> nonempty)
    else $error("queue read while empty");
  a_wr_grows: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow");

endmodule

/* src/hsv_back.sv */
module hsv_back (
  input  logic               clk,
  input  logic               rst,
  input  hsv_pkg::hsv_item_t head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output hsv_pkg::hsv_out_t  out_data
);

  localparam int L = hsv_pkg::NST - 1;

  logic [hsv_pkg::NST-1:0] vld;
  hsv_pkg::hsv_work_t st [hsv_pkg::NST];
  hsv_pkg::hsv_work_t nx [hsv_pkg::NST];
  logic adv;
  logic [2*hsv_pkg::CW-1:0] sd;

  assign adv = !vld[L] || out_ready;
  assign pop = adv && head_valid;
  assign out_valid = vld[L];

  always_comb begin
    nx[0].dir = head.dir;
    nx[0].kind = head.kind;
    nx[0].sector = head.sector;
    nx[0].v = head.v;
    nx[0].p0 = (2*hsv_pkg::CW)'(head.s) * (2*hsv_pkg::CW)'(head.q);
    nx[0].p1 = (2*hsv_pkg::CW)'(head.s)
             * (2*hsv_pkg::CW)'({1'b1, {hsv_pkg::CW{1'b0}}} - {1'b0, head.q});
    nx[0].p2 = (2*hsv_pkg::CW)'(head.v) * (2*hsv_pkg::CW)'(hsv_pkg::CMAX - head.s);
    nx[0].f1 = '0;
    nx[0].f2 = '0;
    nx[0].f3 = '0;
    sd = {head.delta, {hsv_pkg::CW{1'b0}}} - (2*hsv_pkg::CW)'(head.delta);
    nx[0].rs = hsv_pkg::DW'(sd[2*hsv_pkg::CW-1:hsv_pkg::CW]);
    nx[0].ls = sd[hsv_pkg::CW-1:0];
    nx[0].ds = hsv_pkg::DW'(head.v);
    nx[0].qs = '0;
    nx[0].rh = head.n;
    nx[0].dh = head.d6;
    nx[0].qh = '0;
  end

  for (genvar k = 1; k < hsv_pkg::NST; k++) begin : g_stage
    logic [hsv_pkg::DW:0] ss, sh;
    always_comb begin
      nx[k] = st[k-1];
      if (k == 1) begin
        nx[k].f1 = hsv_pkg::cdiv(st[k-1].p2);
        nx[k].p0 = (2*hsv_pkg::CW)'(hsv_pkg::CMAX - st[k-1].p0[2*hsv_pkg::CW-1:hsv_pkg::CW]);
        nx[k].p1 = (2*hsv_pkg::CW)'(hsv_pkg::CMAX - st[k-1].p1[2*hsv_pkg::CW-1:hsv_pkg::CW]);
      end
      if (k == 2) begin
        nx[k].p0 = (2*hsv_pkg::CW)'(st[k-1].v) * (2*hsv_pkg::CW)'(st[k-1].p0[hsv_pkg::CW-1:0]);
        nx[k].p1 = (2*hsv_pkg::CW)'(st[k-1].v) * (2*hsv_pkg::CW)'(st[k-1].p1[hsv_pkg::CW-1:0]);
      end
      if (k == 3) begin
        nx[k].f2 = hsv_pkg::cdiv(st[k-1].p0);
        nx[k].f3 = hsv_pkg::cdiv(st[k-1].p1);
      end
      ss = hsv_pkg::div_step(st[k-1].rs, st[k-1].ls[hsv_pkg::CW-1], st[k-1].ds);
      sh = hsv_pkg::div_step(st[k-1].rh, 1'b0, st[k-1].dh);
      nx[k].rs = ss[hsv_pkg::DW:1];
      nx[k].ls = {st[k-1].ls[hsv_pkg::CW-2:0], 1'b0};
      nx[k].qs = {st[k-1].qs[hsv_pkg::CW-2:0], ss[0]};
      nx[k].rh = sh[hsv_pkg::DW:1];
      nx[k].qh = {st[k-1].qh[hsv_pkg::CW-2:0], sh[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[hsv_pkg::NST-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < hsv_pkg::NST; i++) st[i] <= nx[i];
    end
  end

  always_comb begin
    out_data = '0;
    if (st[L].dir == hsv_pkg::DIR_HSB2RGB) begin
      case (st[L].kind)
        hsv_pkg::K_BLACK: out_data = '0;
        hsv_pkg::K_GREY: out_data = {st[L].v, st[L].v, st[L].v};
        default: begin
          case (st[L].sector)
            3'd0: out_data = {st[L].v,  st[L].f3, st[L].f1};
            3'd1: out_data = {st[L].f2, st[L].v,  st[L].f1};
            3'd2: out_data = {st[L].f1, st[L].v,  st[L].f3};
            3'd3: out_data = {st[L].f1, st[L].f2, st[L].v};
            3'd4: out_data = {st[L].f3, st[L].f1, st[L].v};
            default: out_data = {st[L].v, st[L].f1, st[L].f2};
          endcase
        end
      endcase
    end else if (st[L].kind == hsv_pkg::K_FLAT) begin
      out_data = {{hsv_pkg::CW{1'b0}}, {hsv_pkg::CW{1'b0}}, st[L].v};
    end else begin
      out_data = {st[L].qh, st[L].qs, st[L].v};
    end
  end

endmodule

/* src/hsv_rgb_converter.sv */
// channel  signals                        dir  meaning
// in       in_valid in_ready in_data      in   hsb or rgb item
// out      out_valid out_ready out_data   out  rgb or hsb item
// cfg      cfg_we cfg_wdata               in   direction, 0 hsb to rgb
// one item per cycle sustained while no output item waits
// the back pipeline holds a 16-step pipelined divider
// 4-entry queue between classify front and back pipeline
// back pipeline stalls as a whole while the output item waits
// rst synchronous, clears direction, queue and valid bits
module hsv_rgb_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsv_pkg::hsv_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hsv_pkg::hsv_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  logic direction;
  logic full, nonempty, pop, wr;
  hsv_pkg::hsv_item_t fitem, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (cfg_we) begin
      direction <= cfg_wdata;
    end
  end

  assign in_ready = !full;
  assign wr = in_valid && !full;

  hsv_front u_front (
    .dir  (direction),
    .data (in_data),
    .item (fitem)
  );

  hsv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .wdata    (fitem),
    .full     (full),
    .rd       (pop),
    .rdata    (head),
    .nonempty (nonempty)
  );

  hsv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (nonempty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam longint MASK = 65535;
  localparam longint TURN = 65536;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  hsv_pkg::hsv_in_t in_data;
  logic out_valid;
  logic out_ready;
  hsv_pkg::hsv_out_t out_data;
  logic cfg_we;
  logic cfg_wdata;

  hsv_rgb_converter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  hsv_pkg::hsv_in_t pending_items[$];
  hsv_pkg::hsv_out_t expected_colors[$];
  logic conv_dir;
  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  bit hold_send;
  logic in_ready_s;

  function automatic hsv_pkg::hsv_out_t hsb_to_rgb(longint h, longint s, longint v);
    longint h6, sector, q, f1, f2, f3, t, u;
    longint o0, o1, o2;
    hsv_pkg::hsv_out_t r;
    if (v == 0) begin
      o0 = 0; o1 = 0; o2 = 0;
    end else if (s == 0) begin
      o0 = v; o1 = v; o2 = v;
    end else begin
      h6 = h * 6;
      sector = h6 >> 16;
      q = h6 & MASK;
      f1 = v * (MASK - s) / MASK;
      t = (s * q) >> 16;
      f2 = v * (MASK - t) / MASK;
      u = (s * (TURN - q)) >> 16;
      f3 = v * (MASK - u) / MASK;
      case (sector)
        0: begin o0 = v; o1 = f3; o2 = f1; end
        1: begin o0 = f2; o1 = v; o2 = f1; end
        2: begin o0 = f1; o1 = v; o2 = f3; end
        3: begin o0 = f1; o1 = f2; o2 = v; end
        4: begin o0 = f3; o1 = f1; o2 = v; end
        default: begin o0 = v; o1 = f1; o2 = f2; end
      endcase
    end
    r.out_first = o0[15:0];
    r.out_second = o1[15:0];
    r.out_third = o2[15:0];
    return r;
  endfunction

  function automatic hsv_pkg::hsv_out_t rgb_to_hsb(longint r, longint g, longint b);
    longint mx, mn, delta, n;
    hsv_pkg::hsv_out_t o;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    o.out_third = mx[15:0];
    if (delta == 0) begin
      o.out_first = '0;
      o.out_second = '0;
    end else begin
      o.out_second = 16'(delta * MASK / mx);
      if (r == mx) n = g - b;
      else if (g == mx) n = 2 * delta + b - r;
      else n = 4 * delta + r - g;
      if (n < 0) n += 6 * delta;
      o.out_first = 16'((n * TURN) / (6 * delta));
    end
    return o;
  endfunction

  function automatic hsv_pkg::hsv_out_t predict_color(hsv_pkg::hsv_in_t it);
    if (conv_dir == hsv_pkg::DIR_HSB2RGB)
      return hsb_to_rgb(it.in_first, it.in_second, it.in_third);
    return rgb_to_hsb(it.in_first, it.in_second, it.in_third);
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!(in_valid && !in_ready_s)) begin
      if (pending_items.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // in_ready as seen at the last rising edge, with acceptance tracked there
  always @(posedge clk) begin
    if (!rst && in_valid) begin
      if (in_ready) begin
        expected_colors.push_back(predict_color(in_data));
      end
      in_ready_s <= in_ready;
    end else begin
      in_ready_s <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    hsv_pkg::hsv_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        $error("unexpected item %h", out_data);
        errors++;
      end else begin
        e = expected_colors.pop_front();
        if (e.out_first !== out_data.out_first) begin
          $error("out_first exp %h got %h", e.out_first, out_data.out_first);
          errors++;
        end
        if (e.out_second !== out_data.out_second) begin
          $error("out_second exp %h got %h", e.out_second, out_data.out_second);
          errors++;
        end
        if (e.out_third !== out_data.out_third) begin
          $error("out_third exp %h got %h", e.out_third, out_data.out_third);
          errors++;
        end
      end
    end
  end

  function automatic hsv_pkg::hsv_in_t mk(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    hsv_pkg::hsv_in_t it;
    it.in_first = a; it.in_second = b; it.in_third = c;
    return it;
  endfunction

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(16));
      3: return 16'(65535 - $urandom_range(16));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    while (expected_colors.size() > 0 || pending_items.size() > 0 || in_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_dir(logic d);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 0;
    conv_dir = d;
  endtask

  task automatic random_block(int count);
    logic [15:0] a;
    for (int i = 0; i < count; i++) begin
      a = rand_chan();
      case ($urandom_range(5))
        0: pending_items.push_back(mk(a, a, a));
        1: pending_items.push_back(mk(a, a, rand_chan()));
        2: pending_items.push_back(mk(rand_chan(), a, a));
        default: pending_items.push_back(mk(a, rand_chan(), rand_chan()));
      endcase
    end
  endtask

  initial begin
    rst = 1; in_valid = 0; in_data = '0; out_ready = 0;
    cfg_we = 0; cfg_wdata = 0; conv_dir = 0; errors = 0; hold_send = 0;
    send_idle_pct = 13; recv_idle_pct = 46;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    set_dir(0);
    pending_items.push_back(mk(16'h1234, 16'hffff, 16'h0000));
    pending_items.push_back(mk(16'h5555, 16'h0000, 16'h8000));
    pending_items.push_back(mk(16'h0000, 16'hffff, 16'hffff));
    pending_items.push_back(mk(16'hffff, 16'hffff, 16'hffff));
    for (int k = 0; k < 6; k++)
      pending_items.push_back(mk(16'(k * 10923 + 100), 16'hc000, 16'hffff));
    pending_items.push_back(mk(16'h2aab, 16'h0001, 16'h0001));
    drain();
    set_dir(1);
    pending_items.push_back(mk(16'h0000, 16'h0000, 16'h0000));
    pending_items.push_back(mk(16'hffff, 16'hffff, 16'hffff));
    pending_items.push_back(mk(16'hffff, 16'hffff, 16'h0000));
    pending_items.push_back(mk(16'h0000, 16'hffff, 16'hffff));
    pending_items.push_back(mk(16'hffff, 16'h0000, 16'hffff));
    pending_items.push_back(mk(16'hffff, 16'h0000, 16'h0001));
    pending_items.push_back(mk(16'h0010, 16'hffff, 16'h0020));
    pending_items.push_back(mk(16'h0020, 16'h0010, 16'hffff));
    pending_items.push_back(mk(16'h0001, 16'h0000, 16'h0000));
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 46; recv_idle_pct = 13;
      end else if (ph == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      set_dir(ph % 2 == 0 ? 1'b0 : 1'b1);
      random_block(95);
      if (ph == 1) begin
        repeat (60) @(posedge clk);
        hold_send = 1;
        while (expected_colors.size() > 0 || in_valid) @(posedge clk);
        hold_send = 0;
      end
      random_block(95);
      drain();
    end
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: errors");
    $finish;
  end
endmodule
